[rtl/core/strided_iir_filter_defines.svh]
`ifndef STRIDED_IIR_FILTER_DEFINES_SVH
`define STRIDED_IIR_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SIF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sif_pkg.sv]
package sif_pkg;

  // fixed field widths of the request and the register port
  localparam int CMD_W = 2;
  localparam int IDX_W = 5;
  localparam int CNT_W = 5;
  localparam int SPC_W = 4;
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 5;

  // product sum width, wraps modulo 2^64
  localparam int ACC_W = 64;

  // request commands
  localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_FF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_FB = 2'd2;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_TAP_COUNT   = 1'b0;
  localparam logic [CFG_AW-1:0] REG_TAP_SPACING = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FF,
    ST_FB,
    ST_DRAIN,
    ST_ROUND,
    ST_SAT
  } seq_state_t;

  // sequencer to multiply-accumulate control
  typedef struct packed {
    logic clear;
    logic term;
    logic use_fb;
    logic coef_ok;
    logic ring_ok;
    logic round;
  } mac_ctl_t;

endpackage

[rtl/core/sif_ram.sv]
module sif_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/sif_mac.sv]
`include "strided_iir_filter_defines.svh"

module sif_mac #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sif_pkg::mac_ctl_t      ctl,
  input  logic [COEF_BITS-1:0]   ff_coef,
  input  logic [COEF_BITS-1:0]   fb_coef,
  input  logic [SAMPLE_BITS-1:0] x_data,
  input  logic [SAMPLE_BITS-1:0] y_data,
  output logic [SAMPLE_BITS-1:0] result
);

  localparam int ACC_W  = sif_pkg::ACC_W;
  localparam int FRAC   = COEF_BITS - 8;
  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = $signed((ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1));
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [COEF_BITS-1:0]   coef_op;
  logic signed [SAMPLE_BITS-1:0] smp_op;
  logic signed [PROD_W-1:0]      prod_r;
  logic                          prod_vld_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       rnd_r;
  logic signed [ACC_W-1:0]       rnd_nxt;

  // operand select, missing coefficient or history reads as zero
  always_comb begin
    coef_op = ctl.use_fb ? $signed(fb_coef) : $signed(ff_coef);
    smp_op  = ctl.use_fb ? $signed(y_data) : $signed(x_data);
    if (!ctl.coef_ok) begin
      coef_op = '0;
    end
    if (!ctl.ring_ok) begin
      smp_op = '0;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    prod_r <= coef_op * smp_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.term;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round to nearest, ties up, then drop the fraction
  assign rnd_nxt = (acc_r + $signed(HALF)) >>> FRAC;

  always_ff @(posedge clk) begin
    if (ctl.round) begin
      rnd_r <= rnd_nxt;
    end
  end

  // saturate to the sample range
  always_comb begin
    if (rnd_r > SAT_HI) begin
      result = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rnd_r < SAT_LO) begin
      result = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = rnd_r[SAMPLE_BITS-1:0];
    end
  end

  `SIF_ASSERT_NEXT(a_acc_cleared, ctl.clear, acc_r == '0, "accumulator not cleared at start")

endmodule

[rtl/core/sif_seq.sv]
`include "strided_iir_filter_defines.svh"

module sif_seq #(
  parameter int MAX_TAPS    = 16,
  parameter int MAX_SPACING = 8,
  parameter int RING_DEPTH  = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [$clog2(MAX_TAPS+1)-1:0]     n_eff,
  input  logic [$clog2(MAX_SPACING+1)-1:0]  s_eff,
  input  logic [MAX_TAPS:0]                 ff_vld,
  input  logic [MAX_TAPS:0]                 fb_vld,
  input  logic                              out_free,
  output logic                              idle,
  output logic [$clog2(MAX_TAPS+1)-1:0]     coef_raddr,
  output logic [$clog2(RING_DEPTH)-1:0]     ring_raddr,
  output logic [$clog2(RING_DEPTH)-1:0]     pos,
  output sif_pkg::mac_ctl_t                 ctl,
  output logic                              sat_go
);

  localparam int TAB_AW = $clog2(MAX_TAPS + 1);
  localparam int RA_W   = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);

  sif_pkg::seq_state_t state_r;
  sif_pkg::seq_state_t state_nxt;

  logic [TAB_AW-1:0] k_r;
  logic [RA_W-1:0]   ra_r;
  logic [RA_W-1:0]   pos_r;
  logic [FILL_W-1:0] fill_r;
  logic              dcnt_r;
  logic              term_r;
  logic              fb_r;
  logic              cok_r;
  logic              rok_r;
  logic              last;
  logic              issue;
  logic [RA_W-1:0]   dec_src;
  logic [RA_W:0]     wrap_sum;
  logic [RA_W-1:0]   dec;

  assign last = (k_r == n_eff);

  // ring address step back by the spacing, wrapping at the ring depth
  always_comb begin
    dec_src  = (state_r == sif_pkg::ST_FF && last) ? pos_r : ra_r;
    wrap_sum = {1'b0, dec_src} + (RA_W + 1)'(RING_DEPTH) - (RA_W + 1)'(s_eff);
    if (dec_src >= RA_W'(s_eff)) begin
      dec = dec_src - RA_W'(s_eff);
    end else begin
      dec = wrap_sum[RA_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sif_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = sif_pkg::ST_FF;
        end
      end
      sif_pkg::ST_FF: begin
        if (last) begin
          state_nxt = (n_eff == '0) ? sif_pkg::ST_DRAIN : sif_pkg::ST_FB;
        end
      end
      sif_pkg::ST_FB: begin
        if (last) begin
          state_nxt = sif_pkg::ST_DRAIN;
        end
      end
      sif_pkg::ST_DRAIN: begin
        if (dcnt_r) begin
          state_nxt = sif_pkg::ST_ROUND;
        end
      end
      sif_pkg::ST_ROUND: begin
        state_nxt = sif_pkg::ST_SAT;
      end
      sif_pkg::ST_SAT: begin
        if (out_free) begin
          state_nxt = sif_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sif_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    issue       = (state_r == sif_pkg::ST_FF) || (state_r == sif_pkg::ST_FB);
    idle        = (state_r == sif_pkg::ST_IDLE);
    sat_go      = (state_r == sif_pkg::ST_SAT) && out_free;
    ctl.clear   = start;
    ctl.term    = term_r;
    ctl.use_fb  = fb_r;
    ctl.coef_ok = cok_r;
    ctl.ring_ok = rok_r;
    ctl.round   = (state_r == sif_pkg::ST_ROUND);
  end

  assign coef_raddr = k_r;
  assign ring_raddr = ra_r;
  assign pos        = pos_r;

  // state, ring position and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sif_pkg::ST_IDLE;
      pos_r   <= '0;
      fill_r  <= '0;
      dcnt_r  <= 1'b0;
      term_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= (state_r == sif_pkg::ST_DRAIN) ? ~dcnt_r : 1'b0;
      term_r  <= issue;
      if (sat_go) begin
        pos_r <= (pos_r == RA_W'(RING_DEPTH - 1)) ? '0 : pos_r + RA_W'(1);
        if (fill_r != FILL_W'(RING_DEPTH)) begin
          fill_r <= fill_r + FILL_W'(1);
        end
      end
    end
  end

  // tap walk and read qualifiers, one term per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      k_r  <= '0;
      ra_r <= pos_r;
    end else if (state_r == sif_pkg::ST_FF && last) begin
      k_r  <= TAB_AW'(1);
      ra_r <= dec;
    end else if (issue) begin
      k_r  <= k_r + TAB_AW'(1);
      ra_r <= dec;
    end
    fb_r  <= (state_r == sif_pkg::ST_FB);
    cok_r <= (state_r == sif_pkg::ST_FB) ? fb_vld[k_r] : ff_vld[k_r];
    rok_r <= (FILL_W'(ra_r) < fill_r) || ((state_r == sif_pkg::ST_FF) && (ra_r == pos_r));
  end

  `SIF_ASSERT_IMPLY(a_k_bound, issue, k_r <= n_eff, "tap index beyond the filter order")
  `SIF_ASSERT_IMPLY(a_ring_addr, issue, (ra_r < RING_DEPTH) && (pos_r < RING_DEPTH), "ring address out of range")
  `SIF_ASSERT_NEXT(a_walk_start, start, (state_r == sif_pkg::ST_FF) && (k_r == '0) && (ra_r == $past(pos_r)), "tap walk did not start at the newest sample")
  `SIF_ASSERT_NEXT(a_pos_step, sat_go, (pos_r == $past(pos_r) + RA_W'(1)) || (pos_r == '0), "ring position did not advance")

endmodule

[rtl/core/strided_iir_filter.sv]
// Direct form I IIR filter with taps spaced tap_spacing samples apart. A request
// on the in_ channel carries a command in in_tuser: filter a sample, or load one
// feedforward or (already negated) feedback coefficient. Loads give no result. A
// sample is worked through to its result before the next sample can be
// accepted, N being the effective order: one shared multiply-accumulate unit
// takes one term per cycle (N+1 feedforward, N feedback terms) off the single
// read ports of the coefficient tables and history rings, followed by a
// pipeline drain, a rounding step and a saturation step. The result sits in an
// output register; a further sample waits only if that register is still full
// when its own result is ready. Input and output histories start at zero after
// reset through a fill count, with no clearing pass. Register 0 is tap_count,
// register 1 is tap_spacing.
module strided_iir_filter #(
  parameter int MAX_TAPS    = 16,
  parameter int MAX_SPACING = 8,
  parameter int RING_DEPTH  = 256,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // coef_index, coef_value, sample_in
  input  logic [((sif_pkg::IDX_W+COEF_BITS+SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // command
  input  logic [sif_pkg::CMD_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // sample_out
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]   out_tdata,
  input  logic                               cfg_we,
  input  logic [sif_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [sif_pkg::CFG_DW-1:0]         cfg_wdata
);

  localparam int IDX_W  = sif_pkg::IDX_W;
  localparam int TAB_AW = $clog2(MAX_TAPS + 1);
  localparam int SP_W   = $clog2(MAX_SPACING + 1);
  localparam int RA_W   = $clog2(RING_DEPTH);
  localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [sif_pkg::CNT_W-1:0] tap_count_r;
  logic [sif_pkg::SPC_W-1:0] tap_spacing_r;
  logic [TAB_AW-1:0]         n_eff;
  logic [SP_W-1:0]           s_eff;

  logic                      accept;
  logic [IDX_W-1:0]          in_index;
  logic [COEF_BITS-1:0]      in_coef;
  logic [SAMPLE_BITS-1:0]    in_sample;
  logic                      idx_ok;
  logic [TAB_AW-1:0]         wr_idx;
  logic                      ff_we;
  logic                      fb_we;
  logic                      x_we;

  logic [MAX_TAPS:0]         ff_vld_r;
  logic [MAX_TAPS:0]         fb_vld_r;

  logic                      idle;
  logic [TAB_AW-1:0]         coef_raddr;
  logic [RA_W-1:0]           ring_raddr;
  logic [RA_W-1:0]           pos;
  sif_pkg::mac_ctl_t         ctl;
  logic                      sat_go;
  logic                      out_free;

  logic [COEF_BITS-1:0]      ff_coef;
  logic [COEF_BITS-1:0]      fb_coef;
  logic [SAMPLE_BITS-1:0]    x_data;
  logic [SAMPLE_BITS-1:0]    y_data;
  logic [SAMPLE_BITS-1:0]    result;

  logic                      out_vld_r;
  logic [SAMPLE_BITS-1:0]    out_data_r;

  // request unpacking
  assign accept    = in_tvalid && in_tready;
  assign in_tready = idle;
  assign in_index  = in_tdata[IDX_W-1:0];
  assign in_coef   = in_tdata[IDX_W +: COEF_BITS];
  assign in_sample = in_tdata[IDX_W+COEF_BITS +: SAMPLE_BITS];
  assign idx_ok    = (in_index <= MAX_TAPS);
  assign wr_idx    = TAB_AW'(in_index);
  assign ff_we     = accept && (in_tuser == sif_pkg::CMD_LOAD_FF) && idx_ok;
  assign fb_we     = accept && (in_tuser == sif_pkg::CMD_LOAD_FB) && idx_ok;
  assign x_we      = accept && (in_tuser == sif_pkg::CMD_SAMPLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r   <= '0;
      tap_spacing_r <= sif_pkg::SPC_W'(1);
    end else if (cfg_we) begin
      if (cfg_addr == sif_pkg::REG_TAP_COUNT) begin
        tap_count_r <= cfg_wdata[sif_pkg::CNT_W-1:0];
      end
      if (cfg_addr == sif_pkg::REG_TAP_SPACING) begin
        tap_spacing_r <= cfg_wdata[sif_pkg::SPC_W-1:0];
      end
    end
  end

  // clamp order and spacing to the supported range
  always_comb begin
    if (tap_count_r > MAX_TAPS) begin
      n_eff = TAB_AW'(MAX_TAPS);
    end else begin
      n_eff = TAB_AW'(tap_count_r);
    end
    if (tap_spacing_r == '0) begin
      s_eff = SP_W'(1);
    end else if (tap_spacing_r > MAX_SPACING) begin
      s_eff = SP_W'(MAX_SPACING);
    end else begin
      s_eff = SP_W'(tap_spacing_r);
    end
  end

  // coefficient written flags, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_vld_r <= '0;
      fb_vld_r <= '0;
    end else begin
      if (ff_we) begin
        ff_vld_r[wr_idx] <= 1'b1;
      end
      if (fb_we) begin
        fb_vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  // coefficient tables
  sif_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS + 1)) u_ff_tab (
    .clk   (clk),
    .we    (ff_we),
    .waddr (wr_idx),
    .wdata (in_coef),
    .raddr (coef_raddr),
    .rdata (ff_coef)
  );

  sif_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS + 1)) u_fb_tab (
    .clk   (clk),
    .we    (fb_we),
    .waddr (wr_idx),
    .wdata (in_coef),
    .raddr (coef_raddr),
    .rdata (fb_coef)
  );

  // input and output history rings
  sif_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_x_ring (
    .clk   (clk),
    .we    (x_we),
    .waddr (pos),
    .wdata (in_sample),
    .raddr (ring_raddr),
    .rdata (x_data)
  );

  sif_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_y_ring (
    .clk   (clk),
    .we    (sat_go),
    .waddr (pos),
    .wdata (result),
    .raddr (ring_raddr),
    .rdata (y_data)
  );

  // sequencer
  sif_seq #(
    .MAX_TAPS    (MAX_TAPS),
    .MAX_SPACING (MAX_SPACING),
    .RING_DEPTH  (RING_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (x_we),
    .n_eff      (n_eff),
    .s_eff      (s_eff),
    .ff_vld     (ff_vld_r),
    .fb_vld     (fb_vld_r),
    .out_free   (out_free),
    .idle       (idle),
    .coef_raddr (coef_raddr),
    .ring_raddr (ring_raddr),
    .pos        (pos),
    .ctl        (ctl),
    .sat_go     (sat_go)
  );

  // shared multiply-accumulate unit
  sif_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .ff_coef (ff_coef),
    .fb_coef (fb_coef),
    .x_data  (x_data),
    .y_data  (y_data),
    .result  (result)
  );

  // output register
  assign out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (sat_go) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sat_go) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'(out_data_r);

endmodule

[test/tb_strided_iir_filter.sv]
`timescale 1ns / 100ps

module tb_strided_iir_filter;
  import sif_pkg::*;

  localparam int MAX_TAPS      = 16;
  localparam int MAX_SPACING   = 8;
  localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 16;
  localparam int RANDOM_ITEMS  = 1950;

  // command 3 has no meaning and must be dropped by the block
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] coef;
    logic signed [23:0] sample;
  } filter_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // coef_index, coef_value, sample_in
  logic [63:0]         in_tdata = '0;
  // command
  logic [CMD_W-1:0]    in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // sample_out
  logic [23:0]         out_tdata;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  // filter state as the block should hold it
  logic signed [31:0]  ff_coef [0:MAX_TAPS];
  logic signed [31:0]  fb_coef [0:MAX_TAPS];
  logic signed [23:0]  x_hist [0:255];
  logic signed [23:0]  y_hist [0:255];
  logic [7:0]          hist_pos;
  logic [CNT_W-1:0]    order_reg;
  logic [SPC_W-1:0]    spacing_reg;

  filter_req_t         pending_reqs [$];
  filter_req_t         current_req;
  logic [23:0]         expected_samples [$];
  logic [23:0]         want_sample;

  int                  gap_max = 0;
  int                  stall_max = 0;
  int                  gap_left = 0;
  int                  stall_left = 0;
  int                  items_sent = 0;
  int                  fail_count = 0;

  strided_iir_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // one filtered sample: strided taps over both histories, round, saturate
  function automatic logic [23:0] filter_sample(logic signed [23:0] x);
    int         order;
    int         stride;
    logic [7:0] tap;
    longint     acc;
    longint     v;
    order  = (order_reg > MAX_TAPS) ? MAX_TAPS : int'(order_reg);
    stride = (spacing_reg == 0) ? 1 :
             (spacing_reg > MAX_SPACING) ? MAX_SPACING : int'(spacing_reg);
    x_hist[hist_pos] = x;
    acc = 0;
    for (int k = 0; k <= order; k++) begin
      tap = 8'(int'(hist_pos) - k * stride);
      acc += longint'(ff_coef[k]) * longint'(x_hist[tap]);
    end
    for (int k = 1; k <= order; k++) begin
      tap = 8'(int'(hist_pos) - k * stride);
      acc += longint'(fb_coef[k]) * longint'(y_hist[tap]);
    end
    // round half up, then drop the 24 fraction bits of the coefficients
    acc += longint'(1) << 23;
    v = acc >>> 24;
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    y_hist[hist_pos] = v[23:0];
    hist_pos = hist_pos + 8'd1;
    return v[23:0];
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      gap_left = 0;
    end else if (!in_tvalid || in_tready) begin
      // request taken at this edge: update the expected state
      if (in_tvalid) begin
        case (current_req.cmd)
          CMD_SAMPLE: expected_samples.push_back(filter_sample(current_req.sample));
          CMD_LOAD_FF: if (current_req.idx <= MAX_TAPS) ff_coef[current_req.idx] = current_req.coef;
          CMD_LOAD_FB: if (current_req.idx <= MAX_TAPS) fb_coef[current_req.idx] = current_req.coef;
          default: ;
        endcase
      end
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        current_req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {3'b000, current_req.sample, current_req.coef, current_req.idx};
        in_tuser  <= current_req.cmd;
        gap_left = $urandom_range(gap_max, 0);
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result %h arrived with none expected", $realtime, out_tdata);
          fail_count++;
        end else begin
          want_sample = expected_samples.pop_front();
          if (out_tdata !== want_sample) begin
            if (fail_count < 10)
              $display("%0t: sample_out expected %h got %h", $realtime, want_sample,
                       out_tdata);
            fail_count++;
          end
        end
        stall_left = $urandom_range(stall_max, 0);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_req(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                          logic signed [31:0] coef, logic signed [23:0] sample);
    filter_req_t r;
    r.cmd    = cmd;
    r.idx    = idx;
    r.coef   = coef;
    r.sample = sample;
    pending_reqs.push_back(r);
    items_sent++;
  endtask

  // all requests taken, all results back, pipeline drained
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    if (addr == REG_TAP_COUNT) order_reg = value;
    else spacing_reg = value[SPC_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly modest coefficients so the output does not sit at the rails
  function automatic logic signed [31:0] draw_coef(int order);
    logic signed [31:0] c;
    c = $urandom;
    if ($urandom_range(7, 0) != 0) c = c >>> (8 + $clog2(order + 2));
    return c;
  endfunction

  function automatic logic signed [23:0] draw_sample();
    logic signed [23:0] s;
    s = 24'($urandom);
    if ($urandom_range(3, 0) == 0) s = s >>> 6;
    return s;
  endfunction

  initial begin
    int n_set;
    int n_eff;
    logic [CFG_DW-1:0] s_set;

    foreach (ff_coef[i]) begin
      ff_coef[i] = '0;
      fb_coef[i] = '0;
    end
    foreach (x_hist[i]) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    hist_pos    = '0;
    order_reg   = '0;
    spacing_reg = 4'd1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: order zero, plain gain through ff tap zero
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sd12345);
    push_req(CMD_LOAD_FF, 5'd0, 32'sh0080_0000, 24'sd0);
    // exact half rounds toward plus infinity
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sd1);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, -24'sd1);
    // saturation at both rails
    push_req(CMD_LOAD_FF, 5'd0, 32'sh7FFF_FFFF, 24'sd0);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sh7F_FFFF);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sh80_0000);
    push_req(CMD_LOAD_FF, 5'd0, 32'sh8000_0000, 24'sd0);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sh7F_FFFF);
    // loads past the table end and the unused command are dropped
    push_req(CMD_LOAD_FF, 5'd17, 32'sh1234_5678, 24'sd0);
    push_req(CMD_LOAD_FB, 5'd31, 32'shFEDC_BA98, 24'sd0);
    push_req(CMD_UNUSED, 5'd0, 32'shFFFF_FFFF, 24'shFF_FFFF);
    // feedback tap zero is stored but never used
    push_req(CMD_LOAD_FB, 5'd0, 32'sh7FFF_FFFF, 24'sd0);
    push_req(CMD_LOAD_FF, 5'd0, 32'sh0100_0000, 24'sd0);
    push_req(CMD_LOAD_FF, 5'd16, 32'sh0040_0000, 24'sd0);
    push_req(CMD_LOAD_FB, 5'd16, -32'sh0040_0000, 24'sd0);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sh80_0000);
    wait_idle();

    // order above the limit, spacing zero
    write_reg(REG_TAP_COUNT, 5'd31);
    write_reg(REG_TAP_SPACING, 5'd0);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sh7F_FFFF);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sh80_0000);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sd0);
    wait_idle();

    // full order, spacing above the limit
    write_reg(REG_TAP_COUNT, 5'd16);
    write_reg(REG_TAP_SPACING, 5'd15);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sh7F_FFFF);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, -24'sd4096);
    push_req(CMD_SAMPLE, 5'd0, 32'sd0, 24'sh40_0000);

    // random phases: new settings, a full coefficient set, then a sample run
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(5, 0))
        0: n_set = 0;
        1: n_set = MAX_TAPS;
        2: n_set = $urandom_range(31, MAX_TAPS + 1);
        default: n_set = $urandom_range(MAX_TAPS, 1);
      endcase
      case ($urandom_range(4, 0))
        0: s_set = 5'd0;
        1: s_set = 5'd1;
        2: s_set = CFG_DW'(MAX_SPACING);
        default: s_set = CFG_DW'($urandom);
      endcase
      write_reg(REG_TAP_COUNT, CFG_DW'(n_set));
      write_reg(REG_TAP_SPACING, s_set);
      gap_max   = ($urandom_range(3, 0) == 0) ? 0 : 7;
      stall_max = ($urandom_range(3, 0) == 0) ? 0 : 7;
      n_eff = (n_set > MAX_TAPS) ? MAX_TAPS : n_set;
      for (int k = 0; k <= n_eff; k++)
        push_req(CMD_LOAD_FF, IDX_W'(k), draw_coef(n_eff), draw_sample());
      for (int k = 1; k <= n_eff; k++)
        push_req(CMD_LOAD_FB, IDX_W'(k), draw_coef(n_eff), draw_sample());
      repeat ($urandom_range(120, 40)) begin
        if ($urandom_range(15, 0) == 0)
          push_req(CMD_W'($urandom), IDX_W'($urandom), $urandom, 24'($urandom));
        else
          push_req(CMD_SAMPLE, IDX_W'($urandom), $urandom, draw_sample());
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("strided_iir_filter verification clean");
    end else begin
      $display("strided_iir_filter verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("strided_iir_filter verification failed");
    $finish;
  end

endmodule
